FILE: hdl/aes_pkg.sv
// Shared types, S-box tables and GF(2^8) helpers for the AES cipher pipeline.
`default_nettype none
package aes_pkg;

    // Round stages in the pipeline: 14 rounds plus the final key addition
    localparam int NUM_STAGES         = 15;
    localparam int MAX_ROUND_KEYS_DEF = 15;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_ENC  = 2'd1,
        CMD_DEC  = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_128 = 2'd0,
        MODE_192 = 2'd1,
        MODE_256 = 2'd2,
        MODE_ALT = 2'd3
    } key_mode_t;

    // One request as it travels down the pipeline
    typedef struct packed {
        logic         valid;
        cmd_t         cmd;
        logic         key_set;
        logic [3:0]   key_index;
        logic [127:0] state;
        logic         last;
    } item_t;

    typedef logic [7:0] sbox_t [256];

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] aa;
        p  = 8'h00;
        aa = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ aa;
            aa = xtime(aa);
        end
        return p;
    endfunction

    // Field inverse by search, then the affine map; evaluated at elaboration only
    function automatic sbox_t gen_fwd_sbox();
        sbox_t      tbl;
        logic [7:0] inv;
        for (int v = 0; v < 256; v++) begin
            inv = 8'h00;
            for (int b = 1; b < 256; b++) begin
                if (gmul(8'(v), 8'(b)) == 8'h01) inv = 8'(b);
            end
            tbl[v] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                   ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        end
        return tbl;
    endfunction

    function automatic sbox_t gen_inv_sbox();
        sbox_t fwd;
        sbox_t tbl;
        fwd = gen_fwd_sbox();
        for (int v = 0; v < 256; v++) begin
            tbl[fwd[v]] = 8'(v);
        end
        return tbl;
    endfunction

    localparam sbox_t FWD_SBOX = gen_fwd_sbox();
    localparam sbox_t INV_SBOX = gen_inv_sbox();

    // MixColumns / InvMixColumns on one column, row 0 in bits 31:24
    function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inverse);
        logic [7:0] a [4];
        logic [7:0] b [4];
        for (int r = 0; r < 4; r++) a[r] = col[31 - 8*r -: 8];
        for (int r = 0; r < 4; r++) begin
            if (inverse)
                b[r] = gmul(8'd14, a[r]) ^ gmul(8'd11, a[(r+1)%4])
                     ^ gmul(8'd13, a[(r+2)%4]) ^ gmul(8'd9, a[(r+3)%4]);
            else
                b[r] = xtime(a[r]) ^ xtime(a[(r+1)%4]) ^ a[(r+1)%4]
                     ^ a[(r+2)%4] ^ a[(r+3)%4];
        end
        return {b[0], b[1], b[2], b[3]};
    endfunction

    function automatic logic [3:0] rounds_of(input key_mode_t mode);
        logic [3:0] n;
        unique case (mode)
            MODE_128: n = 4'd10;
            MODE_192: n = 4'd12;
            default:  n = 4'd14;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/aes_round_stage.sv
// One cipher round stage with its own encryption and decryption round key.
`default_nettype none
module aes_round_stage
    import aes_pkg::*;
#(
    parameter int STAGE          = 0,
    parameter int MAX_ROUND_KEYS = MAX_ROUND_KEYS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       advance,
    input  wire key_mode_t  key_mode,
    input  wire item_t      item_in,
    output item_t           item_out
);

    localparam logic [3:0] STG = 4'(STAGE);

    logic [127:0] round_key;
    logic [7:0]   t  [16];
    logic [7:0]   sf [16];
    logic [7:0]   si [16];
    logic [127:0] shifted;
    logic [127:0] mixed;
    logic [3:0]   nrounds;
    logic         inverse;

    // Round key registers exist only where the store reaches this stage
    if (STAGE < MAX_ROUND_KEYS) begin : g_key
        logic [127:0] enc_key_reg;
        logic [127:0] dec_key_reg;

        // Write when a key load request leaves this stage
        always_ff @(posedge aclk) begin
            if (advance && item_in.valid && item_in.cmd == CMD_LOAD
                    && item_in.key_index == STG) begin
                if (item_in.key_set) dec_key_reg <= item_in.state;
                else                 enc_key_reg <= item_in.state;
            end
        end

        assign round_key = (item_in.cmd == CMD_DEC) ? dec_key_reg : enc_key_reg;
    end else begin : g_nokey
        assign round_key = '0;
    end

    assign inverse = (item_in.cmd == CMD_DEC);
    assign nrounds = rounds_of(key_mode);

    // AddRoundKey, then ShiftRows and SubBytes in both directions
    always_comb begin
        for (int i = 0; i < 16; i++)
            t[i] = item_in.state[127 - 8*i -: 8] ^ round_key[127 - 8*i -: 8];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sf[r + 4*c]             = FWD_SBOX[t[r + 4*((c + r) % 4)]];
                si[r + 4*((c + r) % 4)] = INV_SBOX[t[r + 4*c]];
            end
        end
        for (int i = 0; i < 16; i++)
            shifted[127 - 8*i -: 8] = inverse ? si[i] : sf[i];
    end

    // Mix each column
    always_comb begin
        for (int c = 0; c < 4; c++)
            mixed[127 - 32*c -: 32] = mix_col(shifted[127 - 32*c -: 32], inverse);
    end

    // Pick full round, last round, final key addition or pass
    always_comb begin
        item_out = item_in;
        if (item_in.cmd == CMD_ENC || item_in.cmd == CMD_DEC) begin
            priority if (STG + 4'd1 < nrounds)
                item_out.state = mixed;
            else if (STG + 4'd1 == nrounds)
                item_out.state = shifted;
            else if (STG == nrounds)
                item_out.state = item_in.state ^ round_key;
            else
                item_out.state = item_in.state;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/aes_block_cipher_ecb.sv
// A request is registered on entry and again at the output of every round stage.
// Throughput: one request per cycle; the unrolled chain of 15 round stages sets latency.
// The whole pipeline advances together and holds while a result waits for m_tready.
// Reset (aresetn low, synchronous) clears the stage valid bits and selects AES-128;
// round keys are not cleared and must be loaded before use.
`default_nettype none
module aes_block_cipher_ecb
    import aes_pkg::*;
#(
    parameter int MAX_ROUND_KEYS = MAX_ROUND_KEYS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_wdata,     // key_length_mode
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,       // data_high[63:0], data_low[127:64]
    input  wire logic [6:0]   s_tuser,       // command[1:0], key_set[2], key_index[6:3]
    input  wire logic         s_tlast,       // last_block
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,       // result_high[63:0], result_low[127:64]
    output logic              m_tlast        // result_last
);

    key_mode_t mode_reg;
    item_t     pipe_reg  [NUM_STAGES + 1];
    item_t     pipe_next [NUM_STAGES + 1];
    logic      advance;

    // Mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_128;
        end else if (cfg_we) begin
            mode_reg <= key_mode_t'(cfg_wdata);
        end
    end

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    // Capture the incoming request, state in byte order
    always_comb begin
        pipe_next[0].valid     = s_tvalid;
        pipe_next[0].cmd       = cmd_t'(s_tuser[1:0]);
        pipe_next[0].key_set   = s_tuser[2];
        pipe_next[0].key_index = s_tuser[6:3];
        pipe_next[0].state     = {s_tdata[63:0], s_tdata[127:64]};
        pipe_next[0].last      = s_tlast;
    end

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
        aes_round_stage #(
            .STAGE          (k),
            .MAX_ROUND_KEYS (MAX_ROUND_KEYS)
        ) u_round (
            .aclk     (aclk),
            .advance  (advance),
            .key_mode (mode_reg),
            .item_in  (pipe_reg[k]),
            .item_out (pipe_next[k + 1])
        );
    end

    // Advance the whole pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= NUM_STAGES; k++) pipe_reg[k].valid <= 1'b0;
        end else if (advance) begin
            for (int k = 0; k <= NUM_STAGES; k++) pipe_reg[k] <= pipe_next[k];
        end
    end

    // Drop key loads and unknown commands at the end
    assign m_tvalid = pipe_reg[NUM_STAGES].valid
                   && (pipe_reg[NUM_STAGES].cmd == CMD_ENC
                       || pipe_reg[NUM_STAGES].cmd == CMD_DEC);
    assign m_tdata  = {pipe_reg[NUM_STAGES].state[63:0], pipe_reg[NUM_STAGES].state[127:64]};
    assign m_tlast  = pipe_reg[NUM_STAGES].last;

    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_reg[NUM_STAGES].valid && pipe_reg[NUM_STAGES].cmd == CMD_LOAD |-> !m_tvalid)
        else $error("key load request produced a result");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> pipe_reg[0].valid)
        else $error("accepted request not captured");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_reg[0].valid && !advance |=> pipe_reg[0].valid && $stable(pipe_reg[0].state))
        else $error("stalled stage lost its request");

endmodule
`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for the AES ECB block cipher pipeline.
`timescale 1ns / 100ps
module tb_top;
    import aes_pkg::*;

    localparam int NUM_KEYS   = 15;
    localparam int DRAIN_WAIT = 40;

    typedef struct {
        logic [63:0] res_high;
        logic [63:0] res_low;
        logic        res_last;
    } block_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_wdata = MODE_128;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;     // data_high[63:0], data_low[127:64]
    logic [6:0]   s_tuser = '0;     // command[1:0], key_set[2], key_index[6:3]
    logic         s_tlast = 1'b0;   // last_block
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;          // result_high[63:0], result_low[127:64]
    logic         m_tlast;          // result_last

    // Predictor state
    logic [7:0]    sub_fwd [256];
    logic [7:0]    sub_inv [256];
    logic [63:0]   enc_keys [2*NUM_KEYS];
    logic [63:0]   dec_keys [2*NUM_KEYS];
    key_mode_t     key_len_q = MODE_128;
    block_result_t pending_blocks [$];

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int sink_hold_left = 0;
    int n_fail = 0;
    int n_sent = 0;
    int n_blocks = 0;

    aes_block_cipher_ecb uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    // Build both substitution tables: field inverse as x^254, then the affine map
    task automatic build_sub_tables();
        logic [7:0] inv;
        logic [7:0] s;
        for (int v = 0; v < 256; v++) begin
            inv = 8'h01;
            for (int i = 0; i < 254; i++) inv = gf_mul(inv, 8'(v));
            if (v == 0) inv = 8'h00;
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
              ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sub_fwd[v] = s;
            sub_inv[s] = 8'(v);
        end
    endtask

    // Fetch round key idx as 16 bytes; keys beyond the store read as zero
    function automatic void fetch_key(input logic dec, input int idx, output logic [7:0] k [16]);
        logic [63:0] hi;
        logic [63:0] lo;
        hi = '0;
        lo = '0;
        if (idx < NUM_KEYS) begin
            hi = dec ? dec_keys[2*idx] : enc_keys[2*idx];
            lo = dec ? dec_keys[2*idx+1] : enc_keys[2*idx+1];
        end
        for (int i = 0; i < 8; i++) begin
            k[i]   = hi[63-8*i -: 8];
            k[8+i] = lo[63-8*i -: 8];
        end
    endfunction

    // Run the full cipher on one block with the current key length
    function automatic logic [127:0] aes_cipher_block(input logic dec, input logic [63:0] hi,
                                                      input logic [63:0] lo);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] k [16];
        logic [7:0] col [4];
        logic [7:0] acc;
        logic [7:0] mcoef [4];
        int         nrounds;
        nrounds = (key_len_q == MODE_128) ? 10 : (key_len_q == MODE_192) ? 12 : 14;
        if (dec) mcoef = '{8'd14, 8'd11, 8'd13, 8'd9};
        else     mcoef = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int i = 0; i < 8; i++) begin
            s[i]   = hi[63-8*i -: 8];
            s[8+i] = lo[63-8*i -: 8];
        end
        for (int rnd = 0; rnd < nrounds; rnd++) begin
            fetch_key(dec, rnd, k);
            for (int i = 0; i < 16; i++) t[i] = s[i] ^ k[i];
            // shift rows and substitute; byte r+4c is row r, column c
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++) begin
                    if (dec) s[r + 4*((c+r)%4)] = sub_inv[t[r + 4*c]];
                    else     s[r + 4*c] = sub_fwd[t[r + 4*((c+r)%4)]];
                end
            if (rnd + 1 < nrounds) begin
                for (int c = 0; c < 4; c++) begin
                    for (int r = 0; r < 4; r++) col[r] = s[4*c+r];
                    for (int r = 0; r < 4; r++) begin
                        acc = 8'h00;
                        for (int j = 0; j < 4; j++) acc ^= gf_mul(mcoef[(j-r+4)%4], col[j]);
                        s[4*c+r] = acc;
                    end
                end
            end
        end
        fetch_key(dec, nrounds, k);
        for (int i = 0; i < 16; i++) s[i] ^= k[i];
        for (int i = 0; i < 8; i++) begin
            hi[63-8*i -: 8] = s[i];
            lo[63-8*i -: 8] = s[8+i];
        end
        return {lo, hi};
    endfunction

    // Offer one request, idling at random, and predict it once accepted
    task automatic send_request(input cmd_t cmd, input logic kset, input logic [3:0] kidx,
                                input logic [63:0] hi, input logic [63:0] lo, input logic last);
        logic [127:0] res;
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {lo, hi};
        s_tuser  <= {kidx, kset, cmd};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        n_sent++;
        case (cmd)
            CMD_LOAD: begin
                if (kidx < NUM_KEYS) begin
                    if (kset) begin
                        dec_keys[2*kidx] = hi;
                        dec_keys[2*kidx+1] = lo;
                    end else begin
                        enc_keys[2*kidx] = hi;
                        enc_keys[2*kidx+1] = lo;
                    end
                end
            end
            CMD_ENC, CMD_DEC: begin
                res = aes_cipher_block(cmd == CMD_DEC, hi, lo);
                pending_blocks.push_back('{res[63:0], res[127:64], last});
            end
            default: ;
        endcase
    endtask

    // Drop valid, let every result drain, then allow for in-flight key loads
    task automatic drain_pipeline();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending_blocks.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic set_key_length(input key_mode_t mode);
        drain_pipeline();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(negedge aclk);
        cfg_we <= 1'b0;
        key_len_q = mode;
    endtask

    task automatic load_all_keys();
        for (int i = 0; i < NUM_KEYS; i++) begin
            send_request(CMD_LOAD, 1'b0, 4'(i), {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
            send_request(CMD_LOAD, 1'b1, 4'(i), {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
        end
    endtask

    // Extremes of data, both operations, ignored loads, the unknown command and each key length
    task automatic test_directed();
        load_all_keys();
        send_request(CMD_ENC, 1'b0, 4'd0, '0, '0, 1'b0);
        send_request(CMD_ENC, 1'b1, 4'd15, '1, '1, 1'b1);
        send_request(CMD_DEC, 1'b0, 4'd0, '0, '0, 1'b1);
        send_request(CMD_DEC, 1'b1, 4'd15, '1, '1, 1'b0);
        send_request(CMD_LOAD, 1'b0, 4'd15, '1, '1, 1'b1);
        send_request(CMD_LOAD, 1'b1, 4'd15, '1, '1, 1'b0);
        send_request(CMD_NONE, 1'b1, 4'd15, '1, '1, 1'b1);
        send_request(CMD_ENC, 1'b0, 4'd0, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1);
        for (int m = MODE_192; m <= MODE_ALT; m++) begin
            set_key_length(key_mode_t'(m));
            send_request(CMD_ENC, 1'b0, 4'd0, '1, '0, 1'b1);
            send_request(CMD_DEC, 1'b0, 4'd0, '0, '1, 1'b0);
        end
    endtask

    // Mostly cipher requests with random content, a few key reloads and no-ops
    task automatic test_random(input int n, input int src_pct, input int sink_pct,
                               input key_mode_t mode);
        int pick;
        set_key_length(mode);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_request(CMD_LOAD, 1'($urandom), 4'($urandom),
                             {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom));
            else if (pick < 12)
                send_request(CMD_NONE, 1'($urandom), 4'($urandom),
                             {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom));
            else
                send_request(pick < 56 ? CMD_ENC : CMD_DEC, 1'($urandom), 4'($urandom),
                             {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom));
        end
    endtask

    // Hold the result side off for a long stretch while requests keep coming
    task automatic test_backpressure();
        set_key_length(MODE_256);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        sink_hold_left = 300;
        for (int i = 0; i < 60; i++)
            send_request(i % 2 ? CMD_DEC : CMD_ENC, 1'b0, 4'd0,
                         {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom));
    endtask

    // Result side: random stalls plus the long hold-off
    always @(negedge aclk) begin
        if (sink_hold_left > 0) begin
            m_tready <= 1'b0;
            sink_hold_left <= sink_hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge aclk) begin
        block_result_t exp_blk;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_blocks.size() == 0) begin
                $error("unexpected result %h", m_tdata);
                n_fail++;
            end else begin
                exp_blk = pending_blocks.pop_front();
                n_blocks++;
                if (m_tdata[63:0] !== exp_blk.res_high) begin
                    $error("result_high expected %h got %h", exp_blk.res_high, m_tdata[63:0]);
                    n_fail++;
                end
                if (m_tdata[127:64] !== exp_blk.res_low) begin
                    $error("result_low expected %h got %h", exp_blk.res_low, m_tdata[127:64]);
                    n_fail++;
                end
                if (m_tlast !== exp_blk.res_last) begin
                    $error("result_last expected %b got %b", exp_blk.res_last, m_tlast);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("aes_block_cipher_ecb: mismatch");
        $finish;
    end

    initial begin
        build_sub_tables();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random(460, 0, 0, MODE_128);
        test_random(460, 59, 0, MODE_192);
        test_random(460, 0, 59, MODE_256);
        test_random(460, 17, 17, MODE_ALT);
        test_backpressure();
        set_key_length(MODE_128);
        test_random(40, 30, 30, MODE_128);
        drain_pipeline();
        if (pending_blocks.size() != 0) n_fail++;
        $display("Sent %0d requests over all key lengths, checked %0d cipher blocks,",
                 n_sent, n_blocks);
        $display("with source gaps, sink stalls and a long sink hold-off.");
        if (n_fail == 0)
            $display("aes_block_cipher_ecb: match");
        else
            $display("aes_block_cipher_ecb: mismatch");
        $finish;
    end
endmodule

FILE: aes_block_cipher_ecb.f
hdl/aes_pkg.sv
hdl/aes_round_stage.sv
hdl/aes_block_cipher_ecb.sv
test/tb_top.sv
